// File: rtl/idt_pkg.sv
// Shared types and constants for the interface-definition tokenizer.
// Holds the result beat layout, token kind and error codes, queue sizing.
// No dependencies; every rtl file refers to it by scoped names.
package idt_pkg;

    // Default width of the line, column and length counters
    localparam int POSITION_BITS_DEFAULT = 16;

    // Tab width after reset
    localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;

    // Result queue sizing (depth is a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Token kinds
    localparam logic [2:0] KIND_PUNCT  = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COMMENT = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;
    localparam logic [1:0] ERR_CHAR    = 2'd3;

    // One result beat
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [1:0]  error_code;
        logic [7:0]  lead_char;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } result_t;

endpackage

// File: rtl/idt_scan.sv
// Scanner core: mode and position registers plus the per-byte next-state logic.
// Produces zero, one or two result beats for each stepped byte.
// Depends on idt_pkg.
module idt_scan #(
    parameter int POSITION_BITS = idt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        char_in,
    input  logic [4:0]        tab_width,
    output idt_pkg::result_t  res_first,
    output idt_pkg::result_t  res_second,
    output logic [1:0]        res_count
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [8:0] {
        MODE_IDLE  = 9'b000000001,
        MODE_SLASH = 9'b000000010,
        MODE_LINE  = 9'b000000100,
        MODE_BLOCK = 9'b000001000,
        MODE_STAR  = 9'b000010000,
        MODE_IDENT = 9'b000100000,
        MODE_NUM   = 9'b001000000,
        MODE_STR   = 9'b010000000,
        MODE_ERR   = 9'b100000000
    } scan_mode_t;

    function automatic logic [POSITION_BITS-1:0] sat_add(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b
    );
        logic [POSITION_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[POSITION_BITS] ? POS_MAX : sum[POSITION_BITS-1:0];
    endfunction

    // Counters map onto the 16-bit result fields
    function automatic logic [15:0] pos_out(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+15:0] ext;
        ext = {16'd0, v};
        return ext[15:0];
    endfunction

    function automatic idt_pkg::result_t make_res(
        input logic [2:0]               kind,
        input logic [1:0]               code,
        input logic [7:0]               lead,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col,
        input logic [POSITION_BITS-1:0] len
    );
        idt_pkg::result_t r;
        r.token_kind   = kind;
        r.error_code   = code;
        r.lead_char    = lead;
        r.start_line   = pos_out(line);
        r.start_column = pos_out(col);
        r.token_length = pos_out(len);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z], CH_UNDER};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_DIG_0:CH_DIG_9]};
    endfunction

    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] open_line_reg, open_line_next;
    logic [POSITION_BITS-1:0] open_col_reg, open_col_next;
    logic [POSITION_BITS-1:0] open_len_reg, open_len_next;
    logic [7:0]               open_char_reg, open_char_next;

    logic                     word_emit, case_emit, idle_emit, idle_run;
    idt_pkg::result_t         word_res, case_res, idle_res;
    logic [POSITION_BITS-1:0] base_col, col_blk, len_inc, col_after_len;

    assign len_inc       = sat_add(open_len_reg, POS_ONE);
    assign col_after_len = sat_add(col_reg, open_len_reg);

    // Per-byte next state
    always_comb begin
        mode_next      = mode_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        open_line_next = open_line_reg;
        open_col_next  = open_col_reg;
        open_len_next  = open_len_reg;
        open_char_next = open_char_reg;
        word_emit      = 1'b0;
        case_emit      = 1'b0;
        idle_emit      = 1'b0;
        idle_run       = 1'b0;
        word_res       = '0;
        case_res       = '0;
        idle_res       = '0;
        col_blk        = col_reg;

        case (mode_reg)
            MODE_IDLE: begin
                idle_run = 1'b1;
            end
            MODE_SLASH: begin
                if (char_in == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (char_in == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else begin
                    // lone slash
                    case_emit = 1'b1;
                    case_res  = make_res(idt_pkg::KIND_ERROR, idt_pkg::ERR_CHAR, CH_SLASH,
                                         open_line_reg, open_col_reg, '0);
                    mode_next = MODE_ERR;
                end
            end
            MODE_LINE: begin
                if (char_in == CH_NUL || char_in == CH_LF) begin
                    idle_run = 1'b1;
                end
            end
            MODE_BLOCK, MODE_STAR: begin
                if (char_in == CH_NUL) begin
                    case_emit = 1'b1;
                    case_res  = make_res(idt_pkg::KIND_ERROR, idt_pkg::ERR_COMMENT, CH_SLASH,
                                         open_line_reg, open_col_reg, '0);
                    mode_next = MODE_ERR;
                end else if (mode_reg == MODE_STAR && char_in == CH_SLASH) begin
                    mode_next = MODE_IDLE;
                end else begin
                    // a held star that did not close the comment counts now
                    col_blk = (mode_reg == MODE_STAR) ? sat_add(col_reg, POS_ONE) : col_reg;
                    if (char_in == CH_STAR) begin
                        mode_next = MODE_STAR;
                        col_next  = col_blk;
                    end else if (char_in == CH_LF) begin
                        mode_next = MODE_BLOCK;
                        line_next = sat_add(line_reg, POS_ONE);
                        col_next  = POS_ONE;
                    end else begin
                        mode_next = MODE_BLOCK;
                        col_next  = sat_add(col_blk, POS_ONE);
                    end
                end
            end
            MODE_IDENT: begin
                if (is_alpha(char_in) || is_digit(char_in)) begin
                    open_len_next = len_inc;
                end else begin
                    word_emit = 1'b1;
                    word_res  = make_res(idt_pkg::KIND_IDENT, idt_pkg::ERR_NONE, open_char_reg,
                                         open_line_reg, open_col_reg, open_len_reg);
                    idle_run  = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(char_in)) begin
                    open_len_next = len_inc;
                end else begin
                    word_emit = 1'b1;
                    word_res  = make_res(idt_pkg::KIND_NUMBER, idt_pkg::ERR_NONE, open_char_reg,
                                         open_line_reg, open_col_reg, open_len_reg);
                    idle_run  = 1'b1;
                end
            end
            MODE_STR: begin
                if (char_in == CH_NUL || char_in == CH_LF) begin
                    case_emit = 1'b1;
                    case_res  = make_res(idt_pkg::KIND_ERROR, idt_pkg::ERR_STRING, CH_QUOTE,
                                         open_line_reg, open_col_reg, '0);
                    mode_next = MODE_ERR;
                end else begin
                    open_len_next = len_inc;
                    if (char_in == CH_QUOTE) begin
                        case_emit = 1'b1;
                        case_res  = make_res(idt_pkg::KIND_STRING, idt_pkg::ERR_NONE,
                                             open_char_reg, open_line_reg, open_col_reg,
                                             len_inc);
                        col_next  = sat_add(col_reg, len_inc);
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_ERR: begin
                mode_next = MODE_ERR;
            end
            default: begin
                mode_next = MODE_ERR;
            end
        endcase

        // Between-token handling, also for the byte that closes a word
        base_col = word_emit ? col_after_len : col_reg;
        if (idle_run) begin
            mode_next = MODE_IDLE;
            col_next  = base_col;
            case (char_in)
                CH_NUL: begin
                    idle_emit      = 1'b1;
                    idle_res       = make_res(idt_pkg::KIND_END, idt_pkg::ERR_NONE, CH_NUL,
                                              line_reg, base_col, POS_ONE);
                    line_next      = POS_ONE;
                    col_next       = POS_ONE;
                    open_line_next = POS_ONE;
                    open_col_next  = POS_ONE;
                    open_len_next  = '0;
                    open_char_next = '0;
                end
                CH_TAB: begin
                    col_next = sat_add(base_col, POSITION_BITS'(tab_width));
                end
                CH_SPACE: begin
                    col_next = sat_add(base_col, POS_ONE);
                end
                CH_LF: begin
                    line_next = sat_add(line_reg, POS_ONE);
                    col_next  = POS_ONE;
                end
                CH_CR, CH_BS, CH_VT: begin
                    col_next = base_col;
                end
                CH_SLASH, CH_QUOTE: begin
                    open_line_next = line_reg;
                    open_col_next  = base_col;
                    open_len_next  = POS_ONE;
                    open_char_next = char_in;
                    mode_next      = (char_in == CH_SLASH) ? MODE_SLASH : MODE_STR;
                end
                CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                CH_STAR, CH_COMMA, CH_SEMI, CH_EQUAL: begin
                    idle_emit = 1'b1;
                    idle_res  = make_res(idt_pkg::KIND_PUNCT, idt_pkg::ERR_NONE, char_in,
                                         line_reg, base_col, POS_ONE);
                    col_next  = sat_add(base_col, POS_ONE);
                end
                default: begin
                    if (is_alpha(char_in) || is_digit(char_in)) begin
                        open_line_next = line_reg;
                        open_col_next  = base_col;
                        open_len_next  = POS_ONE;
                        open_char_next = char_in;
                        mode_next      = is_alpha(char_in) ? MODE_IDENT : MODE_NUM;
                    end else begin
                        idle_emit = 1'b1;
                        idle_res  = make_res(idt_pkg::KIND_ERROR, idt_pkg::ERR_CHAR, char_in,
                                             line_reg, base_col, '0);
                        mode_next = MODE_ERR;
                    end
                end
            endcase
        end
    end

    // Result slots: a closed word goes first, the byte's own result second
    always_comb begin
        res_count  = {1'b0, case_emit} + {1'b0, word_emit} + {1'b0, idle_emit};
        res_first  = case_emit ? case_res : (word_emit ? word_res : idle_res);
        res_second = idle_res;
        res_first.last_of_run  = (res_count == 2'd1);
        res_second.last_of_run = 1'b1;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            line_reg      <= POS_ONE;
            col_reg       <= POS_ONE;
            open_line_reg <= POS_ONE;
            open_col_reg  <= POS_ONE;
            open_len_reg  <= '0;
            open_char_reg <= '0;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            open_line_reg <= open_line_next;
            open_col_reg  <= open_col_next;
            open_len_reg  <= open_len_next;
            open_char_reg <= open_char_next;
        end
    end

endmodule

// File: rtl/idt_result_fifo.sv
// Result queue: takes up to two result beats per cycle, hands out one.
// Reports room whenever two more beats fit regardless of the pop.
// Depends on idt_pkg.
module idt_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  idt_pkg::result_t  push_first,
    input  idt_pkg::result_t  push_second,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output idt_pkg::result_t  out_data
);

    idt_pkg::result_t                 entries_reg [idt_pkg::FIFO_DEPTH];
    logic [idt_pkg::FIFO_PTR_W-1:0]   head_reg, head_next;
    logic [idt_pkg::FIFO_PTR_W-1:0]   tail_reg, tail_next, tail_plus1;
    logic [idt_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                             pop;

    assign out_valid  = (count_reg != '0);
    assign out_data   = entries_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= idt_pkg::FIFO_CNT_W'(idt_pkg::FIFO_DEPTH - 2));
    assign tail_plus1 = tail_reg + idt_pkg::FIFO_PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb begin
        head_next  = pop ? head_reg + idt_pkg::FIFO_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + idt_pkg::FIFO_PTR_W'(push_count);
        count_next = count_reg + idt_pkg::FIFO_CNT_W'(push_count)
                   - idt_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entries_reg[tail_reg] <= push_first;
        end
        if (push_count == 2'd2) begin
            entries_reg[tail_plus1] <= push_second;
        end
    end

endmodule

// File: rtl/interface_definition_tokenizer_unit.sv
// Top level of the interface-definition tokenizer.
// Input byte register, scanner core (idt_scan) and result queue (idt_result_fifo).
// Depends on idt_pkg, idt_scan and idt_result_fifo.
//
//  Channel   Dir  Handshake            Beat
//  s_        in   s_valid / s_ready    s_source_byte
//  m_        out  m_valid / m_ready    m_token_kind .. m_last_of_run
//  cfg_      in   cfg_wr_en            cfg_wr_data (tab width)
//
// One byte per cycle while two queue slots are free; a byte waits in the input register
// until the scan step moves its results into the queue, from which they are offered.
// A byte that closes an identifier or number gives two beats when it has a result
// of its own, so that byte then takes two slots of the result queue.
// Synchronous active-low reset returns position, mode and tab width to defaults.
// The input register keeps taking bytes while finished beats wait in the queue;
// the scan step stalls only when fewer than two queue slots are free.
module interface_definition_tokenizer_unit #(
    parameter int POSITION_BITS = idt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [1:0]  m_error_code,
    output logic [7:0]  m_lead_char,
    output logic [15:0] m_start_line,
    output logic [15:0] m_start_column,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic [4:0]       tab_width_reg;
    logic             fire, room, s_take;
    logic [1:0]       scan_count, push_count;
    idt_pkg::result_t scan_first, scan_second, head_res;

    // Step the scanner when a byte is held and two queue slots are free
    assign fire       = in_valid_reg && room;
    assign s_ready    = !in_valid_reg || fire;
    assign s_take     = s_valid && s_ready;
    assign push_count = fire ? scan_count : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register and tab width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            tab_width_reg <= idt_pkg::TAB_WIDTH_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                tab_width_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_source_byte;
        end
    end

    idt_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (fire),
        .char_in    (in_byte_reg),
        .tab_width  (tab_width_reg),
        .res_first  (scan_first),
        .res_second (scan_second),
        .res_count  (scan_count)
    );

    idt_result_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push_first  (scan_first),
        .push_second (scan_second),
        .room        (room),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_data    (head_res)
    );

    // Result beat fields
    assign m_token_kind   = head_res.token_kind;
    assign m_error_code   = head_res.error_code;
    assign m_lead_char    = head_res.lead_char;
    assign m_start_line   = head_res.start_line;
    assign m_start_column = head_res.start_column;
    assign m_token_length = head_res.token_length;
    assign m_last_of_run  = head_res.last_of_run;

    // No beat is offered right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // Two beats from one byte only when a word closes
    a_pair_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && scan_count == 2'd2) |->
        (scan_first.token_kind == idt_pkg::KIND_IDENT ||
         scan_first.token_kind == idt_pkg::KIND_NUMBER))
        else $error("two results without a closing word");

    // An error latches: nothing more is produced after it
    a_error_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ((scan_count == 2'd1 && scan_first.token_kind == idt_pkg::KIND_ERROR) ||
                  (scan_count == 2'd2 && scan_second.token_kind == idt_pkg::KIND_ERROR)))
        |=> (scan_count == 2'd0))
        else $error("result produced after an error");

endmodule

// File: verif/idt_token_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the interface-definition tokenizer: watches the byte, result
// and tab-width ports, predicts every result beat and compares it field by field.
// Depends on idt_pkg for the result layout, token kinds and error codes.
module idt_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_token_kind,
    input  logic [1:0]  m_error_code,
    input  logic [7:0]  m_lead_char,
    input  logic [15:0] m_start_line,
    input  logic [15:0] m_start_column,
    input  logic [15:0] m_token_length,
    input  logic        m_last_of_run,
    output int          token_mismatches,
    output int          tokens_pending
);

    typedef enum logic [8:0] {
        SCAN_IDLE          = 9'b000000001,
        SCAN_SLASH         = 9'b000000010,
        SCAN_LINE_COMMENT  = 9'b000000100,
        SCAN_BLOCK_COMMENT = 9'b000001000,
        SCAN_BLOCK_STAR    = 9'b000010000,
        SCAN_IDENT         = 9'b000100000,
        SCAN_NUMBER        = 9'b001000000,
        SCAN_STRING        = 9'b010000000,
        SCAN_ERROR         = 9'b100000000
    } scan_state_t;

    // Predicted scanner state
    scan_state_t scan_state;
    logic [4:0]  tab_cols;
    logic [15:0] line_now;
    logic [15:0] col_now;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [7:0]  tok_lead;

    // Beats produced by the byte being predicted, and the ones still owed
    idt_pkg::result_t staged [2];
    int               staged_n;
    idt_pkg::result_t expected_tokens [$];
    idt_pkg::result_t want;

    int mismatch_count = 0;
    int beat_index = 0;

    assign token_mismatches = mismatch_count;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= 17'h0FFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void restart_position();
        line_now = 16'd1;
        col_now  = 16'd1;
        tok_line = 16'd1;
        tok_col  = 16'd1;
        tok_len  = 16'd0;
        tok_lead = 8'd0;
    endfunction

    function automatic void stage(input logic [2:0] kind, input logic [1:0] code,
                                  input logic [7:0] lead, input logic [15:0] ln,
                                  input logic [15:0] col, input logic [15:0] len);
        idt_pkg::result_t r;
        r.token_kind   = kind;
        r.error_code   = code;
        r.lead_char    = lead;
        r.start_line   = ln;
        r.start_column = col;
        r.token_length = len;
        r.last_of_run  = 1'b0;
        staged[staged_n] = r;
        staged_n++;
    endfunction

    function automatic void open_token(input logic [7:0] c, input scan_state_t next);
        tok_line   = line_now;
        tok_col    = col_now;
        tok_len    = 16'd1;
        tok_lead   = c;
        scan_state = next;
    endfunction

    function automatic void raise_error(input logic [1:0] code, input logic [7:0] lead,
                                        input logic [15:0] ln, input logic [15:0] col);
        scan_state = SCAN_ERROR;
        stage(idt_pkg::KIND_ERROR, code, lead, ln, col, 16'd0);
    endfunction

    // Byte seen between tokens
    function automatic void step_idle(input logic [7:0] c);
        scan_state = SCAN_IDLE;
        case (c)
            8'h00: begin
                stage(idt_pkg::KIND_END, idt_pkg::ERR_NONE, 8'd0, line_now, col_now, 16'd1);
                restart_position();
            end
            8'h09: col_now = sat_add(col_now, {11'd0, tab_cols});
            " ":   col_now = sat_add(col_now, 16'd1);
            8'h0A: begin
                line_now = sat_add(line_now, 16'd1);
                col_now  = 16'd1;
            end
            8'h0D, 8'h08, 8'h0B: ;
            "/":   open_token(c, SCAN_SLASH);
            "{", "}", "(", ")", "[", "]", "*", ",", ";", "=": begin
                stage(idt_pkg::KIND_PUNCT, idt_pkg::ERR_NONE, c, line_now, col_now, 16'd1);
                col_now = sat_add(col_now, 16'd1);
            end
            "\"":  open_token(c, SCAN_STRING);
            default: begin
                if (is_letter(c))
                    open_token(c, SCAN_IDENT);
                else if (is_digit(c))
                    open_token(c, SCAN_NUMBER);
                else
                    raise_error(idt_pkg::ERR_CHAR, c, line_now, col_now);
            end
        endcase
    endfunction

    // Identifier or number ends on this byte, which is then scanned on its own
    function automatic void close_word(input logic [2:0] kind, input logic [7:0] c);
        stage(kind, idt_pkg::ERR_NONE, tok_lead, tok_line, tok_col, tok_len);
        col_now = sat_add(col_now, tok_len);
        step_idle(c);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        staged_n = 0;
        case (scan_state)
            SCAN_IDLE: step_idle(c);
            SCAN_SLASH: begin
                if (c == "/")
                    scan_state = SCAN_LINE_COMMENT;
                else if (c == "*")
                    scan_state = SCAN_BLOCK_COMMENT;
                else
                    raise_error(idt_pkg::ERR_CHAR, "/", tok_line, tok_col);
            end
            SCAN_LINE_COMMENT: begin
                if (c == 8'h00 || c == 8'h0A)
                    step_idle(c);
            end
            SCAN_BLOCK_COMMENT, SCAN_BLOCK_STAR: begin
                if (c == 8'h00) begin
                    raise_error(idt_pkg::ERR_COMMENT, "/", tok_line, tok_col);
                end else if (scan_state == SCAN_BLOCK_STAR && c == "/") begin
                    scan_state = SCAN_IDLE;
                end else begin
                    // a star that turned out not to close the comment counts now
                    if (scan_state == SCAN_BLOCK_STAR)
                        col_now = sat_add(col_now, 16'd1);
                    if (c == "*") begin
                        scan_state = SCAN_BLOCK_STAR;
                    end else begin
                        scan_state = SCAN_BLOCK_COMMENT;
                        if (c == 8'h0A) begin
                            line_now = sat_add(line_now, 16'd1);
                            col_now  = 16'd1;
                        end else begin
                            col_now = sat_add(col_now, 16'd1);
                        end
                    end
                end
            end
            SCAN_IDENT: begin
                if (is_letter(c) || is_digit(c))
                    tok_len = sat_add(tok_len, 16'd1);
                else
                    close_word(idt_pkg::KIND_IDENT, c);
            end
            SCAN_NUMBER: begin
                if (is_digit(c))
                    tok_len = sat_add(tok_len, 16'd1);
                else
                    close_word(idt_pkg::KIND_NUMBER, c);
            end
            SCAN_STRING: begin
                if (c == 8'h00 || c == 8'h0A) begin
                    raise_error(idt_pkg::ERR_STRING, "\"", tok_line, tok_col);
                end else begin
                    tok_len = sat_add(tok_len, 16'd1);
                    if (c == "\"") begin
                        stage(idt_pkg::KIND_STRING, idt_pkg::ERR_NONE, tok_lead, tok_line,
                              tok_col, tok_len);
                        col_now    = sat_add(col_now, tok_len);
                        scan_state = SCAN_IDLE;
                    end
                end
            end
            default: scan_state = SCAN_ERROR;
        endcase

        for (int i = 0; i < staged_n; i++) begin
            staged[i].last_of_run = (i == staged_n - 1);
            expected_tokens.push_back(staged[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] tokenizer mismatch, beat %0d: %s", $time, beat_index, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
    endtask

    // Sample both channels at each edge, inputs first
    always @(posedge aclk) begin
        if (!aresetn) begin
            tab_cols   = idt_pkg::TAB_WIDTH_RESET;
            scan_state = SCAN_IDLE;
            restart_position();
            expected_tokens.delete();
        end else begin
            if (cfg_wr_en)
                tab_cols = cfg_wr_data;
            if (s_valid && s_ready)
                tokenize_byte(s_source_byte);
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("result beat with no token expected");
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("token_kind", 16'(m_token_kind), 16'(want.token_kind));
                    compare_field("error_code", 16'(m_error_code), 16'(want.error_code));
                    compare_field("lead_char", 16'(m_lead_char), 16'(want.lead_char));
                    compare_field("start_line", m_start_line, want.start_line);
                    compare_field("start_column", m_start_column, want.start_column);
                    compare_field("token_length", m_token_length, want.token_length);
                    compare_field("last_of_run", 16'(m_last_of_run), 16'(want.last_of_run));
                end
                beat_index++;
            end
        end
        tokens_pending <= expected_tokens.size();
    end

endmodule

// File: verif/interface_definition_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, byte stimulus, result stalls,
// tab-width writes and the verdict. Checking lives in idt_token_checker.
// Depends on idt_pkg, idt_token_checker and the tokenizer RTL.
module interface_definition_tokenizer_unit_tb;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_source_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_token_kind;
    logic [1:0]  m_error_code;
    logic [7:0]  m_lead_char;
    logic [15:0] m_start_line;
    logic [15:0] m_start_column;
    logic [15:0] m_token_length;
    logic        m_last_of_run;

    int token_mismatches;
    int tokens_pending;
    int results_taken = 0;
    int bytes_sent = 0;
    int burst_left = 8;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;

    // Character tables for random fragments
    localparam string PUNCT_SET = "{}()[]*,;=";
    localparam string SPACE_SET = " \t\n \n\t\015\010\013";

    always #2 aclk = ~aclk;

    interface_definition_tokenizer_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_byte  (s_source_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_error_code   (m_error_code),
        .m_lead_char    (m_lead_char),
        .m_start_line   (m_start_line),
        .m_start_column (m_start_column),
        .m_token_length (m_token_length),
        .m_last_of_run  (m_last_of_run)
    );

    idt_token_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_source_byte    (s_source_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_error_code     (m_error_code),
        .m_lead_char      (m_lead_char),
        .m_start_line     (m_start_line),
        .m_start_column   (m_start_column),
        .m_token_length   (m_token_length),
        .m_last_of_run    (m_last_of_run),
        .token_mismatches (token_mismatches),
        .tokens_pending   (tokens_pending)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            results_taken <= results_taken + 1;
    end

    // Offer one byte and hold it until the beat is taken; bursts end in a gap
    task automatic send_byte(input logic [7:0] b);
        s_valid       <= 1'b1;
        s_source_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(48, 96)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drain all owed beats, then let the pipeline run empty
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (tokens_pending != 0 && waited < 5000);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_tab_width(input logic [4:0] cols);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cols;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] random_letter();
        int i;
        i = $urandom_range(0, 52);
        if (i < 26)
            return 8'("A" + i);
        else if (i < 52)
            return 8'("a" + i - 26);
        return "_";
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
        return c;
    endfunction

    // True for any byte that can start or continue a legal token sequence
    function automatic bit is_lexical(input logic [7:0] c);
        case (c)
            CH_NUL, 8'h08, CH_TAB, CH_NL, 8'h0B, 8'h0D, " ", "/", "\"",
            "{", "}", "(", ")", "[", "]", "*", ",", ";", "=", "_":
                return 1'b1;
            default:
                return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                       (c >= "0" && c <= "9");
        endcase
    endfunction

    // One well-formed piece of source with random content
    task automatic send_fragment();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            send_byte(random_letter());
            len = $urandom_range(0, 7);
            repeat (len) send_byte($urandom_range(0, 2) == 0 ? random_digit() : random_letter());
        end else if (pick < 36) begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(random_digit());
        end else if (pick < 50) begin
            send_byte(PUNCT_SET[$urandom_range(0, PUNCT_SET.len() - 1)]);
        end else if (pick < 58) begin
            send_byte("\"");
            len = $urandom_range(0, 8);
            repeat (len) send_byte(random_byte_except("\"", CH_NL));
            send_byte("\"");
        end else if (pick < 78) begin
            send_byte(SPACE_SET[$urandom_range(0, SPACE_SET.len() - 1)]);
        end else if (pick < 86) begin
            send_text("//");
            len = $urandom_range(0, 10);
            repeat (len) send_byte(random_byte_except(CH_NL, CH_NL));
            send_byte($urandom_range(0, 5) == 0 ? CH_NUL : CH_NL);
        end else if (pick < 95) begin
            // block comment body never holds a slash, so it closes only at the end
            send_text("/*");
            len = $urandom_range(0, 12);
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0:       send_byte("*");
                    1:       send_byte(CH_NL);
                    default: send_byte(random_byte_except("/", "/"));
                endcase
            end
            send_text("*/");
        end else begin
            send_byte(CH_NUL);
        end
    endtask

    task automatic random_run(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_fragment();
    endtask

    // The error latches until reset, so exactly one error closes the run
    task automatic send_final_error();
        logic [7:0] c;
        int len;
        case ($urandom_range(0, 3))
            0: begin
                do c = 8'($urandom_range(1, 255)); while (is_lexical(c));
                send_byte(c);
            end
            1: begin
                send_byte("/");
                send_byte(random_byte_except("/", "*"));
            end
            2: begin
                send_byte("\"");
                len = $urandom_range(0, 6);
                repeat (len) send_byte(random_byte_except("\"", CH_NL));
                send_byte($urandom_range(0, 1) ? CH_NL : CH_NUL);
            end
            default: begin
                send_text("/*");
                len = $urandom_range(0, 6);
                repeat (len) send_byte(random_byte_except("/", "/"));
                send_byte(CH_NUL);
            end
        endcase
        // these must all be swallowed by the error latch
        send_text("ab 12; \"x\"");
        send_byte(CH_NUL);
    endtask

    // Result side: random ready runs and stalls, one long hold-off
    initial begin
        int run_len;
        int stall_len;
        bit held_off;
        held_off = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held_off && results_taken >= 60) begin
                held_off = 1'b1;
                repeat (80) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            repeat (run_len) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (stall_len) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    // Byte side and verdict
    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 5'd0;
        s_valid       <= 1'b0;
        s_source_byte <= 8'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every token kind except error, both comment forms, all whitespace
        write_tab_width(5'd1);
        send_text("_Z9 5;\t\"\377\"/**\n*/{}()[]*,=//\200\n\015\010\013");
        send_byte(CH_NUL);
        settle();

        write_tab_width(5'd16);
        random_run(140);
        settle();

        write_tab_width(5'd0);
        random_run(140);
        settle();

        write_tab_width(5'd31);
        random_run(140);
        settle();

        write_tab_width(5'($urandom_range(1, 16)));
        random_run(140);
        send_final_error();
        settle();

        if (token_mismatches == 0 && tokens_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/idt_pkg.sv
rtl/idt_scan.sv
rtl/idt_result_fifo.sv
rtl/interface_definition_tokenizer_unit.sv
verif/idt_token_checker.sv
verif/interface_definition_tokenizer_unit_tb.sv
